FILE: hdl/gds_pkg.sv
// Shared types and constants for the grid divergence stencil.
// Used by every module of the block but gds_ram; depends on nothing.
package gds_pkg;

    localparam int GRID_COLS = 128;
    localparam int GRID_ROWS = 128;
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int QDEPTH    = 4;

    // Input request, one grid cell.
    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [23:0]        west_face_len;
        logic [23:0]        south_face_len;
        logic [31:0]        inv_area;
        logic [7:0]         depth_count;
    } t_in_item;

    // Output request, one divergence result.
    typedef struct packed {
        logic signed [47:0] div_value;
        logic [6:0]         out_row;
        logic [6:0]         out_col;
        logic               last_of_run;
    } t_out_item;

    // Line buffer word: what the next row needs from this column.
    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [23:0]        south_len;
    } t_lb;

    // Job handed from front to back: face velocity sums, face lengths, flags.
    typedef struct packed {
        logic signed [32:0] flux_xe;   // ux + prev ux, this column
        logic signed [32:0] flux_xw;   // same, left column
        logic signed [32:0] flux_yc;   // uy + left uy, this row
        logic signed [32:0] flux_yp;   // same, previous row
        logic [23:0]        len_xe;
        logic [23:0]        len_xw;
        logic [23:0]        len_yc;
        logic [23:0]        len_yp;
        logic [31:0]        inv_area;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               active;    // nonzero result possible
        logic               two_out;   // last column follows with a zero
    } t_job;

endpackage

FILE: hdl/grid_divergence_stencil_unit.sv
// Top level of the grid divergence stencil: level register, front, queue, back.
// Depends on gds_pkg, gds_front, gds_queue and gds_back.
//
// Cells of one grid level enter in raster order, one request per cell, and the
// unit returns the finite-volume divergence of each cell, scaled by 2^40 and
// saturated to 48 bits. A cell's result leaves once the cell to its right has
// arrived, so column 0 returns nothing and the last column returns two results
// (its left neighbor, then itself as zero, flagged last_of_run). Row 0 and
// cells whose depth_count does not exceed level_index give zero. The front
// accepts one cell per clock while its 4-entry job queue has room; the back
// runs one job at a time through a shared multiply/round sequencer: an active
// cell passes the product, sum, scale and round states before its results,
// an inactive cell goes straight to them, and output stalls hold either one.
// The previous-row line buffer needs no clearing after reset: it is only
// read for results of row 1 onward, after row 0 has written it.
// level_index may only be written while the unit is idle.
module grid_divergence_stencil_unit
    import gds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    logic [7:0] r_level;   // level_index
    logic       w_push;
    logic       w_q_full;
    logic       w_q_valid;
    logic       w_pop;
    t_job       w_push_job;
    t_job       w_q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cfg_we) begin
            r_level <= i_cfg_wdata;
        end
    end

    // raster tracking, line buffer, left cell and job build
    gds_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_level    (r_level),
        .o_push     (w_push),
        .o_job      (w_push_job),
        .i_q_full   (w_q_full)
    );

    // decouples the per-clock front from the multi-cycle back
    gds_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .o_full     (w_q_full),
        .i_pop      (w_pop),
        .o_valid    (w_q_valid),
        .o_job      (w_q_job)
    );

    // arithmetic and result delivery
    gds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_job       (w_q_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // no job is pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_full))
        else $error("job queue overflow");

    // a non-last result is followed at once by the last-column zero
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.last_of_run |=>
            o_out_valid && o_out.last_of_run && (o_out.div_value == '0) &&
            (o_out.out_col == 7'($past(o_out.out_col) + 7'd1)))
        else $error("last-column result missing");

    // row 0 never yields a nonzero divergence
    a_row0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.div_value != '0) |-> (o_out.out_row != '0))
        else $error("nonzero result on row 0");

endmodule

FILE: hdl/gds_ram.sv
// Generic simple dual-port RAM, registered read.
// No dependencies.
module gds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/gds_queue.sv
// Short job queue between front and back of the divergence stencil.
// Depends on gds_pkg.
module gds_queue
    import gds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_job             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    assign o_full  = (r_cnt == CNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

endmodule

FILE: hdl/gds_front.sv
// Front end: takes cells, keeps raster position, line buffer and left cell,
// and forms one job per cell but column 0. Depends on gds_pkg and gds_ram.
module gds_front
    import gds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in,
    input  logic [7:0] i_level,
    output logic       o_push,
    output t_job       o_job,
    input  logic       i_q_full
);

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic             r_s1_vld;
    t_in_item         r_s1;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;

    // left cell
    logic signed [31:0] r_l_ux;
    logic signed [31:0] r_l_uy;
    logic signed [31:0] r_l_pux;
    logic signed [31:0] r_l_puy;
    logic [23:0]        r_l_htw;
    logic [23:0]        r_l_hts;
    logic [7:0]         r_l_kmt;
    logic [31:0]        r_l_inv;
    logic [23:0]        r_l_phts;

    logic [$bits(t_lb)-1:0] w_rdata;
    t_lb                    w_prev;
    t_lb                    w_wr;
    logic                   w_acc;
    logic                   w_emit;
    logic                   w_go;

    assign w_acc      = i_in_valid && o_in_ready;
    assign w_emit     = (r_s1_col != '0);
    assign w_go       = r_s1_vld && (!w_emit || !i_q_full);
    assign o_in_ready = !r_s1_vld || w_go;
    assign o_push     = w_go && w_emit;

    assign w_prev       = t_lb'(w_rdata);
    assign w_wr.vel_x   = r_s1.vel_x;
    assign w_wr.vel_y   = r_s1.vel_y;
    assign w_wr.south_len = r_s1.south_face_len;

    gds_ram #(
        .WIDTH ($bits(t_lb)),
        .DEPTH (GRID_COLS)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (w_go),
        .i_waddr (r_s1_col),
        .i_wdata (w_wr),
        .i_re    (w_acc),
        .i_raddr (r_col),
        .o_rdata (w_rdata)
    );

    // raster position and stage 1 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (w_acc) begin
                r_s1_vld <= 1'b1;
                if (r_col == COL_W'(GRID_COLS - 1)) begin
                    r_col <= '0;
                    r_row <= (r_row == ROW_W'(GRID_ROWS - 1)) ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end else if (w_go) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1     <= i_in;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
        end
        if (w_go) begin
            r_l_ux   <= r_s1.vel_x;
            r_l_uy   <= r_s1.vel_y;
            r_l_pux  <= w_prev.vel_x;
            r_l_puy  <= w_prev.vel_y;
            r_l_htw  <= r_s1.west_face_len;
            r_l_hts  <= r_s1.south_face_len;
            r_l_kmt  <= r_s1.depth_count;
            r_l_inv  <= r_s1.inv_area;
            r_l_phts <= w_prev.south_len;
        end
    end

    always_comb begin
        o_job.flux_xe  = 33'(r_s1.vel_x) + 33'(w_prev.vel_x);
        o_job.flux_xw  = 33'(r_l_ux) + 33'(r_l_pux);
        o_job.flux_yc  = 33'(r_s1.vel_y) + 33'(r_l_uy);
        o_job.flux_yp  = 33'(w_prev.vel_y) + 33'(r_l_puy);
        o_job.len_xe   = r_s1.west_face_len;
        o_job.len_xw   = r_l_htw;
        o_job.len_yc   = r_l_hts;
        o_job.len_yp   = r_l_phts;
        o_job.inv_area = r_l_inv;
        o_job.row      = r_s1_row;
        o_job.col      = r_s1_col - COL_W'(1);
        o_job.active   = (r_s1_row != '0) && (r_l_kmt > i_level);
        o_job.two_out  = (r_s1_col == COL_W'(GRID_COLS - 1));
    end

endmodule

FILE: hdl/gds_back.sv
// Back end: multiply, round, saturate and deliver the results of one job.
// Depends on gds_pkg.
module gds_back
    import gds_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROD  = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_SCALE = 3'd3;
    localparam logic [2:0] S_RND   = 3'd4;
    localparam logic [2:0] S_OUT1  = 3'd5;
    localparam logic [2:0] S_OUT2  = 3'd6;

    localparam logic [58:0] SAT_MAG = 59'h0000_7FFF_FFFF_FFFF;

    logic [2:0] r_state;
    logic [2:0] n_state;

    t_job               r_job;
    logic signed [57:0] r_p0;
    logic signed [57:0] r_p1;
    logic signed [57:0] r_p2;
    logic signed [57:0] r_p3;
    logic               r_neg;
    logic [58:0]        r_mag;
    logic [63:0]        r_pp0;
    logic [58:0]        r_pp1;
    logic signed [47:0] r_div;

    logic signed [59:0] w_sum;
    logic [64:0]        w_t;
    logic [59:0]        w_qs;
    logic [58:0]        w_q;
    logic signed [47:0] w_div;

    assign o_pop = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_q_valid) n_state = i_job.active ? S_PROD : S_OUT1;
            S_PROD:  n_state = S_SUM;
            S_SUM:   n_state = S_SCALE;
            S_SCALE: n_state = S_RND;
            S_RND:   n_state = S_OUT1;
            S_OUT1:  if (i_out_ready) n_state = r_job.two_out ? S_OUT2 : S_IDLE;
            S_OUT2:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // signed sum of the four face terms, scale 2^24
    assign w_sum = 60'(r_p0) - 60'(r_p1) + 60'(r_p2) - 60'(r_p3);

    // round half away from zero on the magnitude, then drop 33 bits
    assign w_t  = 65'(r_pp0) + 65'h1_0000_0000;
    assign w_qs = 60'(r_pp1) + 60'(w_t[64:32]);
    assign w_q  = w_qs[59:1];

    always_comb begin
        if (r_neg) begin
            w_div = (w_q > SAT_MAG) ? 48'sh8000_0000_0000 : -$signed(w_q[47:0]);
        end else begin
            w_div = (w_q > SAT_MAG) ? 48'sh7FFF_FFFF_FFFF : $signed(w_q[47:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_div <= '0;
        end
        if (r_state == S_PROD) begin
            r_p0 <= 58'(r_job.flux_xe) * 58'($signed({1'b0, r_job.len_xe}));
            r_p1 <= 58'(r_job.flux_xw) * 58'($signed({1'b0, r_job.len_xw}));
            r_p2 <= 58'(r_job.flux_yc) * 58'($signed({1'b0, r_job.len_yc}));
            r_p3 <= 58'(r_job.flux_yp) * 58'($signed({1'b0, r_job.len_yp}));
        end
        if (r_state == S_SUM) begin
            r_neg <= w_sum[59];
            r_mag <= w_sum[59] ? 59'(-w_sum) : 59'(w_sum);
        end
        if (r_state == S_SCALE) begin
            r_pp0 <= 64'(r_mag[31:0]) * 64'(r_job.inv_area);
            r_pp1 <= 59'(r_mag[58:32]) * 59'(r_job.inv_area);
        end
        if (r_state == S_RND) begin
            r_div <= w_div;
        end
    end

    assign o_out_valid = (r_state == S_OUT1) || (r_state == S_OUT2);

    always_comb begin
        o_out.out_row = 7'(r_job.row);
        if (r_state == S_OUT2) begin
            o_out.div_value   = '0;
            o_out.out_col     = 7'(r_job.col + COL_W'(1));
            o_out.last_of_run = 1'b1;
        end else begin
            o_out.div_value   = r_div;
            o_out.out_col     = 7'(r_job.col);
            o_out.last_of_run = !r_job.two_out;
        end
    end

endmodule

FILE: dv/gds_div_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the grid divergence stencil: watches the request, result and level ports,
// predicts each cell divergence and compares it with what the unit returns.
// Depends on gds_pkg.
module gds_div_checker
    import gds_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output int         o_pending,
    output int         o_errors
);

    t_out_item          pending_divs[$];
    logic [7:0]         level;
    // previous row, one word per column
    logic signed [31:0] row_vel_x [GRID_COLS];
    logic signed [31:0] row_vel_y [GRID_COLS];
    logic [23:0]        row_south [GRID_COLS];
    // cell to the left, with the previous-row values at its column
    t_in_item           left_cell;
    logic signed [31:0] left_up_vx;
    logic signed [31:0] left_up_vy;
    logic [23:0]        left_up_south;
    int                 row_pos;
    int                 col_pos;
    int                 mismatches;

    // (s * a) / 2^33, magnitude rounded half away from zero, saturated to 48 bits
    function automatic logic signed [47:0] scaled_div(input longint s, input logic [31:0] a);
        logic [63:0] mag;
        logic [95:0] prod;
        logic [95:0] q;
        mag  = (s < 0) ? -s : s;
        prod = {32'b0, mag} * {64'b0, a};
        q    = (prod + 96'h1_0000_0000) >> 33;
        if (s < 0) begin
            return (q >= 96'h8000_0000_0000) ? 48'h8000_0000_0000 : -q[47:0];
        end
        return (q > 96'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : q[47:0];
    endfunction

    task automatic predict_divergence(input t_in_item c);
        logic signed [31:0] up_vx;
        logic signed [31:0] up_vy;
        logic [23:0]        up_south;
        longint             flux;
        t_out_item          r;
        up_vx    = row_vel_x[col_pos];
        up_vy    = row_vel_y[col_pos];
        up_south = row_south[col_pos];
        if (col_pos >= 1) begin
            r.div_value = '0;
            if (row_pos != 0 && left_cell.depth_count > level) begin
                flux = (longint'($signed(c.vel_x)) + longint'(up_vx))
                           * longint'(c.west_face_len)
                     - (longint'($signed(left_cell.vel_x)) + longint'(left_up_vx))
                           * longint'(left_cell.west_face_len)
                     + (longint'($signed(c.vel_y)) + longint'($signed(left_cell.vel_y)))
                           * longint'(left_cell.south_face_len)
                     - (longint'(up_vy) + longint'(left_up_vy))
                           * longint'(left_up_south);
                r.div_value = scaled_div(flux, left_cell.inv_area);
            end
            r.out_row     = 7'(row_pos);
            r.out_col     = 7'(col_pos - 1);
            r.last_of_run = (col_pos != GRID_COLS - 1);
            pending_divs.push_back(r);
            // last column: its own result is always zero
            if (col_pos == GRID_COLS - 1) begin
                r.div_value   = '0;
                r.out_col     = 7'(col_pos);
                r.last_of_run = 1'b1;
                pending_divs.push_back(r);
            end
        end
        left_cell          = c;
        left_up_vx         = up_vx;
        left_up_vy         = up_vy;
        left_up_south      = up_south;
        row_vel_x[col_pos] = c.vel_x;
        row_vel_y[col_pos] = c.vel_y;
        row_south[col_pos] = c.south_face_len;
        if (col_pos + 1 >= GRID_COLS) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= GRID_ROWS) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic check_div(input t_out_item got);
        t_out_item want;
        if (pending_divs.size() == 0) begin
            $display("%0t unexpected result: expected none, got row %0d col %0d div %0d",
                     $time, got.out_row, got.out_col, got.div_value);
            mismatches++;
        end else begin
            want = pending_divs.pop_front();
            if (got.div_value !== want.div_value) begin
                $display("%0t div_value at row %0d col %0d: expected %0d, got %0d",
                         $time, want.out_row, want.out_col, want.div_value, got.div_value);
                mismatches++;
            end
            if (got.out_row !== want.out_row) begin
                $display("%0t out_row: expected %0d, got %0d",
                         $time, want.out_row, got.out_row);
                mismatches++;
            end
            if (got.out_col !== want.out_col) begin
                $display("%0t out_col: expected %0d, got %0d",
                         $time, want.out_col, got.out_col);
                mismatches++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $display("%0t last_of_run at row %0d col %0d: expected %0b, got %0b",
                         $time, want.out_row, want.out_col, want.last_of_run, got.last_of_run);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < GRID_COLS; k++) begin
                row_vel_x[k] = '0;
                row_vel_y[k] = '0;
                row_south[k] = '0;
            end
            left_cell     = '0;
            left_up_vx    = '0;
            left_up_vy    = '0;
            left_up_south = '0;
            level         = '0;
            row_pos       = 0;
            col_pos       = 0;
            pending_divs.delete();
        end else begin
            // a result always leaves after the request that caused it, so it is checked first
            if (i_out_valid && i_out_ready) check_div(i_out);
            if (i_in_valid && i_in_ready) predict_divergence(i_in);
            if (i_cfg_we) level = i_cfg_wdata;
        end
        o_pending <= pending_divs.size();
        o_errors  <= mismatches;
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench top for grid_divergence_stencil_unit: clock, reset, cell stimulus, idling
// and the verdict. Depends on gds_pkg, grid_divergence_stencil_unit and gds_div_checker.
module tb
    import gds_pkg::*;
();

    localparam int TOTAL_CELLS    = 400;   // requests in the whole run
    localparam int SETTLE_CYCLES  = 32;    // margin after the last result; a column-0 cell gives no result
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off, fills the job queue
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no request or result accepted

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_item   in_req    = '0;
    logic       out_ready = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = '0;
    logic       in_ready;
    logic       out_valid;
    t_out_item  out_res;

    int         pending;
    int         errors;
    int         idle_cycles  = 0;
    int         snd_idle_pct = 0;
    int         rcv_idle_pct = 0;
    int         hold_tag     = 0;
    int         hold_seen    = 0;
    int         hold_left    = 0;
    int         cells_sent   = 0;
    logic [7:0] cur_level    = '0;

    initial begin
        forever #5 clk = ~clk;
    end

    grid_divergence_stencil_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    gds_div_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_req),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // Watchdog: a run that stops moving is a failure.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off each time hold_tag moves.
    always @(posedge clk) begin
        if (hold_seen != hold_tag) begin
            hold_seen <= hold_tag;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    function automatic t_in_item make_cell(input logic [31:0] vx, input logic [31:0] vy,
                                           input logic [23:0] wl, input logic [23:0] sl,
                                           input logic [31:0] inv, input logic [7:0] depth);
        t_in_item c;
        c.vel_x          = vx;
        c.vel_y          = vy;
        c.west_face_len  = wl;
        c.south_face_len = sl;
        c.inv_area       = inv;
        c.depth_count    = depth;
        return c;
    endfunction

    // Mostly ocean-like magnitudes that stay clear of saturation, some full-range
    // cells, and a field forced to an extreme now and then.
    function automatic t_in_item random_cell(input logic [7:0] lvl);
        t_in_item c;
        if ($urandom_range(3) == 0) begin
            c.vel_x          = $urandom;
            c.vel_y          = $urandom;
            c.west_face_len  = 24'($urandom);
            c.south_face_len = 24'($urandom);
            c.inv_area       = $urandom;
        end else begin
            c.vel_x          = $urandom_range(0, 1 << 27) - (1 << 26);
            c.vel_y          = $urandom_range(0, 1 << 27) - (1 << 26);
            c.west_face_len  = 24'($urandom_range(0, 1 << 14));
            c.south_face_len = 24'($urandom_range(0, 1 << 14));
            c.inv_area       = $urandom_range(0, 1 << 24);
        end
        case ($urandom_range(15))
            0: c.vel_x = 32'h7FFF_FFFF;
            1: c.vel_x = 32'h8000_0000;
            2: c.vel_y = 32'h7FFF_FFFF;
            3: c.vel_y = 32'h8000_0000;
            4: c.west_face_len = '1;
            5: c.south_face_len = '1;
            6: c.inv_area = '1;
            7: c.inv_area = '0;
            8: c.vel_x = '0;
            default: ;
        endcase
        // depth around the level so both sides of the active test are hit
        case ($urandom_range(4))
            0: c.depth_count = 8'd0;
            1: c.depth_count = 8'hFF;
            2: c.depth_count = lvl;
            3: c.depth_count = (lvl == 8'hFF) ? lvl : lvl + 8'd1;
            default: c.depth_count = 8'($urandom);
        endcase
        return c;
    endfunction

    // One request: optional idle cycles, then hold valid until accepted.
    task automatic send_cell(input t_in_item c);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        cells_sent++;
    endtask

    task automatic send_random(input int n);
        repeat (n) send_cell(random_cell(cur_level));
    endtask

    // Level writes only with the unit drained and settled.
    task automatic write_level(input logic [7:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_level = v;
    endtask

    task automatic set_phase(input int snd_pct, input int rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct <= rcv_pct;
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        write_level(8'd0);

        // Phase A: sender idles a little, receiver stalls most of the time.
        set_phase(12, 87);

        // Row 0: extremes give zero here; columns 7..15 zero so that row 1 can
        // place exact cases on a clean previous row.
        send_cell(make_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, '1, 8'hFF));
        send_cell(make_cell(32'h8000_0000, 32'h8000_0000, '0, '0, '0, 8'd0));
        send_cell(make_cell(32'h7FFF_FFFF, 32'h8000_0000, '1, '0, '1, 8'd1));
        send_random(4);
        repeat (9) send_cell(make_cell('0, '0, '0, '0, '0, 8'd0));
        send_random(GRID_COLS - 16);

        // Row 1: columns 0..7 random, then directed cells.
        send_random(8);
        send_cell(make_cell('0, '0, '0, '0, 32'd1, 8'd1));              // col 8, area 1
        send_cell(make_cell(32'd1 << 9, '0, 24'd1 << 23, '0, 32'd1, 8'd1)); // col 8: +half
        send_cell(make_cell('0, '0, '0, '0, '0, 8'd1));                 // col 9: -half
        send_cell(make_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, '1, 8'hFF));
        send_cell(make_cell(32'h8000_0000, 32'h7FFF_FFFF, '1, '0, '1, 8'hFF));
        send_cell(make_cell(32'h7FFF_FFFF, 32'h8000_0000, '1, '1, '1, 8'hFF)); // +saturate
        send_cell(make_cell(32'h8000_0000, 32'h8000_0000, '0, '1, '1, 8'hFF)); // -saturate
        send_cell(make_cell('0, '0, '0, '0, '0, 8'd0));                 // dry cell
        send_random(2 * GRID_COLS - cells_sent);   // finishes row 1, last column included

        // Sender pauses until every result is back, then the top level: all dry.
        write_level(8'hFF);

        // Phase B: sender idles most of the time, receiver a little.
        set_phase(87, 12);
        send_random(40);
        write_level(8'($urandom_range(1, 254)));
        send_random(40);

        // Phase C: no idling, one long receiver hold-off at the start, then the
        // rest of the run.
        write_level(8'($urandom_range(0, 3)));
        set_phase(0, 0);
        hold_tag <= hold_tag + 1;
        send_random(TOTAL_CELLS - cells_sent);
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending != 0) $display("%0t results never returned: %0d", $time, pending);
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
